@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros: same-cycle and next-cycle implication checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/fvpp_pkg.sv @@
// ----------------------------------------------------------------------------
// fvpp_pkg
// Types and constants of the framed value packet parser
// ----------------------------------------------------------------------------
`default_nettype none

package fvpp_pkg;

  // parse phase, one-hot
  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_ID    = 6'b000010,
    PH_LEN   = 6'b000100,
    PH_DATA  = 6'b001000,
    PH_CHECK = 6'b010000,
    PH_END   = 6'b100000
  } phase_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_END_BYTE   = 2'd1;
  localparam logic [1:0] REG_VALUE_ID   = 2'd2;

  // register reset values
  localparam logic [7:0] START_BYTE_RST = 8'hAA;
  localparam logic [7:0] END_BYTE_RST   = 8'h55;
  localparam logic [7:0] VALUE_ID_RST   = 8'h01;

  // required payload length of a value frame
  localparam logic [7:0] VALUE_LEN = 8'd2;

endpackage

`default_nettype wire

@@ sv/framed_value_packet_parser.sv @@
// ----------------------------------------------------------------------------
// framed_value_packet_parser
// Hunts start/id/length/payload/checksum/end frames in a byte stream and
// emits the 16-bit big-endian value of each good value frame
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the parse state updates at the edge that
// takes the byte.
// The value is registered and shows on the output in the cycle after its end byte is taken.
// Only an end byte meeting a held, stalled value waits; all else flows.
// Reset (rst, synchronous): hunting for a start byte, no output, registers
// back to start 0xAA, end 0x55, value id 0x01.
`default_nettype none

`include "assert_macros.svh"

module framed_value_packet_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  // value output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      pot_value,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import fvpp_pkg::*;

  // configuration registers
  logic [7:0] start_byte;
  logic [7:0] end_byte;
  logic [7:0] value_msg_id;

  // parse state
  phase_t      phase, phase_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  bytes_received, bytes_received_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] value_bytes, value_bytes_next;
  logic [7:0]  received_check, received_check_next;

  logic       in_fire;
  logic       frame_good;
  logic [8:0] count_inc;
  logic       cfg_write;
  logic [1:0] cfg_index;

  // configuration write and read
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte   <= START_BYTE_RST;
      end_byte     <= END_BYTE_RST;
      value_msg_id <= VALUE_ID_RST;
    end else if (cfg_write) begin
      if (cfg_index == REG_START_BYTE) start_byte <= pwdata[7:0];
      if (cfg_index == REG_END_BYTE) end_byte <= pwdata[7:0];
      if (cfg_index == REG_VALUE_ID) value_msg_id <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (cfg_index == REG_START_BYTE) prdata = {24'd0, start_byte};
    else if (cfg_index == REG_END_BYTE) prdata = {24'd0, end_byte};
    else if (cfg_index == REG_VALUE_ID) prdata = {24'd0, value_msg_id};
  end

  // hold off only an end byte that could meet a stalled value
  assign in_stall = (phase == PH_END) && out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  assign count_inc = {1'b0, bytes_received} + 9'd1;

  // frame parser next state
  always_comb begin
    phase_next          = phase;
    frame_id_next       = frame_id;
    frame_length_next   = frame_length;
    bytes_received_next = bytes_received;
    running_xor_next    = running_xor;
    value_bytes_next    = value_bytes;
    received_check_next = received_check;
    frame_good          = 1'b0;
    unique case (phase)
      PH_START: begin
        if (rx_byte == start_byte) phase_next = PH_ID;
      end
      PH_ID: begin
        frame_id_next    = rx_byte;
        running_xor_next = rx_byte;
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        frame_length_next   = rx_byte;
        running_xor_next    = running_xor ^ rx_byte;
        bytes_received_next = 8'd0;
        value_bytes_next    = 16'd0;
        phase_next          = (rx_byte != 8'd0) ? PH_DATA : PH_CHECK;
      end
      PH_DATA: begin
        running_xor_next = running_xor ^ rx_byte;
        if (bytes_received == 8'd0) value_bytes_next = {rx_byte, 8'd0};
        else if (bytes_received == 8'd1) value_bytes_next = {value_bytes[15:8], rx_byte};
        bytes_received_next = count_inc[7:0];
        if (count_inc >= {1'b0, frame_length}) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        received_check_next = rx_byte;
        phase_next          = PH_END;
      end
      PH_END: begin
        frame_good = (rx_byte == end_byte) && (running_xor == received_check) &&
                     (frame_id == value_msg_id) && (frame_length == VALUE_LEN);
        phase_next = PH_START;
      end
      default: begin
        phase_next = PH_START;
      end
    endcase
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      frame_id       <= 8'd0;
      frame_length   <= 8'd0;
      bytes_received <= 8'd0;
      running_xor    <= 8'd0;
      value_bytes    <= 16'd0;
      received_check <= 8'd0;
    end else if (in_fire) begin
      phase          <= phase_next;
      frame_id       <= frame_id_next;
      frame_length   <= frame_length_next;
      bytes_received <= bytes_received_next;
      running_xor    <= running_xor_next;
      value_bytes    <= value_bytes_next;
      received_check <= received_check_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && frame_good) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && frame_good) begin
      pot_value <= value_bytes;
    end
  end

  // checks
  `ASSERT_IMPL(a_no_overwrite, clk, rst, in_fire && phase == PH_END,
               !(out_valid && out_stall))
  `ASSERT_NEXT(a_no_spurious, clk, rst,
               in_fire && phase != PH_END && !(out_valid && out_stall), !out_valid)
  `ASSERT_NEXT(a_data_count, clk, rst, in_fire && phase == PH_DATA,
               bytes_received == $past(bytes_received) + 8'd1)
  `ASSERT_NEXT(a_zero_len, clk, rst, in_fire && phase == PH_LEN && rx_byte == 8'd0,
               phase == PH_CHECK)

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the framed value packet parser. The parse state is tracked byte by
// byte on every accepted input item. Each value that a good frame should
// yield is queued and compared in order against the output. The run covers
// three register settings and three idling patterns, plus a long output
// hold-off.
// ----------------------------------------------------------------------------
module tb;
  import fvpp_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 10;
  localparam int LONG_HOLD     = 300;

  // parse tracker and queue of values still owed by the block
  class value_frame_tracker;
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [7:0]  value_id;
    phase_t      phase;
    logic [7:0]  frame_id;
    logic [7:0]  frame_len;
    logic [7:0]  taken;
    logic [7:0]  xor_acc;
    logic [7:0]  check_byte;
    logic [15:0] value_bytes;
    logic [15:0] owed_values[$];
    int          failures;

    function new();
      start_byte  = START_BYTE_RST;
      end_byte    = END_BYTE_RST;
      value_id    = VALUE_ID_RST;
      phase       = PH_START;
      frame_id    = '0;
      frame_len   = '0;
      taken       = '0;
      xor_acc     = '0;
      check_byte  = '0;
      value_bytes = '0;
      failures    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_START_BYTE: start_byte = val;
        REG_END_BYTE:   end_byte = val;
        REG_VALUE_ID:   value_id = val;
        default: ;
      endcase
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // advance the parse by one accepted item
    function void take_byte(logic [7:0] b);
      case (phase)
        PH_START: begin
          if (b == start_byte) phase = PH_ID;
        end
        PH_ID: begin
          frame_id = b;
          xor_acc  = b;
          phase    = PH_LEN;
        end
        PH_LEN: begin
          frame_len   = b;
          xor_acc     = xor_acc ^ b;
          taken       = '0;
          value_bytes = '0;
          phase       = (b != 8'h00) ? PH_DATA : PH_CHECK;
        end
        PH_DATA: begin
          xor_acc = xor_acc ^ b;
          // only the first two payload bytes are kept
          if (taken == 8'd0) value_bytes = {b, 8'h00};
          else if (taken == 8'd1) value_bytes[7:0] = b;
          taken = taken + 8'd1;
          if (taken >= frame_len) phase = PH_CHECK;
        end
        PH_CHECK: begin
          check_byte = b;
          phase      = PH_END;
        end
        PH_END: begin
          if (b == end_byte && xor_acc == check_byte && frame_id == value_id &&
              frame_len == VALUE_LEN)
            owed_values.push_back(value_bytes);
          phase = PH_START;
        end
        default: phase = PH_START;
      endcase
    endfunction

    // compare one accepted result with the oldest owed value
    function void check_value(logic [15:0] got);
      logic [15:0] want;
      if (owed_values.size() == 0) begin
        report($sformatf("unexpected pot_value %04h", got));
      end else begin
        want = owed_values.pop_front();
        if (got !== want)
          report($sformatf("pot_value mismatch: expected %04h, got %04h", want, got));
      end
    endfunction

    function int outstanding();
      return owed_values.size();
    endfunction

    // values that never came out
    function void close_out();
      while (owed_values.size() != 0)
        report($sformatf("pot_value %04h never came out", owed_values.pop_front()));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] pot_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  value_frame_tracker tracker;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_hold    = 0;
  int bytes_sent    = 0;
  int cycle_count   = 0;

  framed_value_packet_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pot_value(pot_value),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // output stall: random, or held high for a counted stretch
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        out_stall = 1'b1;
        stall_hold--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.take_byte(rx_byte);
      if (out_valid && !out_stall) tracker.check_value(pot_value);
    end
  end

  // byte biased toward the extremes
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 8'h00;
    else if (r == 1) return 8'hFF;
    else return 8'($urandom);
  endfunction

  // offer one item, idling first at random, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      rx_byte  = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    bytes_sent++;
  endtask

  // full frame; chk_err flips checksum bits, wrong_end swaps in bad_end
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                            input logic [15:0] value, input logic [7:0] chk_err,
                            input logic wrong_end, input logic [7:0] bad_end);
    logic [7:0] sum;
    logic [7:0] b;
    sum = id ^ len;
    send_byte(tracker.start_byte);
    send_byte(id);
    send_byte(len);
    for (int i = 0; i < int'(len); i++) begin
      if (i == 0) b = value[15:8];
      else if (i == 1) b = value[7:0];
      else b = pick_byte();
      sum = sum ^ b;
      send_byte(b);
    end
    send_byte(sum ^ chk_err);
    send_byte(wrong_end ? bad_end : tracker.end_byte);
  endtask

  // register write: setup phase, then access until pready
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'h0, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // stop offering and wait for every owed value
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly good value frames, mixed with rejected frames and loose bytes
  task automatic random_traffic(input int count);
    int target;
    int kind;
    logic [7:0] id;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      kind = $urandom_range(99);
      id   = tracker.value_id;
      if (kind < 55)
        send_frame(id, VALUE_LEN, {pick_byte(), pick_byte()}, 8'h00, 1'b0, 8'h00);
      else if (kind < 65)
        send_frame(id, 8'($urandom_range(9)), {pick_byte(), pick_byte()},
                   8'h00, 1'b0, 8'h00);
      else if (kind < 73)
        send_frame(id ^ 8'($urandom_range(1, 255)), VALUE_LEN,
                   {pick_byte(), pick_byte()}, 8'h00, 1'b0, 8'h00);
      else if (kind < 81)
        send_frame(id, VALUE_LEN, {pick_byte(), pick_byte()},
                   8'($urandom_range(1, 255)), 1'b0, 8'h00);
      else if (kind < 89)
        send_frame(id, VALUE_LEN, {pick_byte(), pick_byte()}, 8'h00, 1'b1,
                   tracker.end_byte ^ 8'($urandom_range(1, 255)));
      else
        repeat ($urandom_range(1, 4)) send_byte(pick_byte());
    end
  endtask

  // main sequence
  initial begin
    tracker  = new();
    rst      = 1'b1;
    in_valid = 1'b0;
    rx_byte  = 8'h00;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    send_idle_pct = 19;
    recv_idle_pct = 85;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset registers: all-ones value, start byte as data, zero length,
    // then a wrong end byte that equals the start byte
    send_frame(VALUE_ID_RST, VALUE_LEN, 16'hFFFF, 8'h00, 1'b0, 8'h00);
    send_frame(VALUE_ID_RST, VALUE_LEN, 16'hAA00, 8'h00, 1'b0, 8'h00);
    send_frame(VALUE_ID_RST, 8'h00, 16'h0000, 8'h00, 1'b0, 8'h00);
    send_frame(VALUE_ID_RST, VALUE_LEN, 16'h1234, 8'h00, 1'b1, START_BYTE_RST);
    random_traffic(70);
    drain();

    // low start byte, high end byte and id; sender idles most
    send_idle_pct = 85;
    recv_idle_pct = 19;
    stall_hold    = LONG_HOLD;
    write_reg(REG_START_BYTE, 8'h00);
    write_reg(REG_END_BYTE, 8'hFF);
    write_reg(REG_VALUE_ID, 8'hFF);
    // back-to-back good frames against the held output
    send_idle_pct = 0;
    repeat (4)
      send_frame(tracker.value_id, VALUE_LEN, {pick_byte(), pick_byte()},
                 8'h00, 1'b0, 8'h00);
    send_idle_pct = 85;
    random_traffic(70);
    drain();

    // high start byte, low end byte and id; no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_START_BYTE, 8'hFF);
    write_reg(REG_END_BYTE, 8'h00);
    write_reg(REG_VALUE_ID, 8'h00);
    // longest payload
    send_frame(tracker.value_id, 8'hFF, 16'h5AA5, 8'h00, 1'b0, 8'h00);
    random_traffic(70);
    drain();

    repeat (8) @(posedge clk);
    tracker.close_out();
    if (tracker.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ framed_value_packet_parser.f @@
+incdir+sv
sv/fvpp_pkg.sv
sv/framed_value_packet_parser.sv
verif/tb.sv
